FILE: sv/upt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upt_pkg
// Shared types and constants of the uplink target-power controller.
// ----------------------------------------------------------------------------
package upt_pkg;

  // Default sizing
  localparam int STATIONS_DEF   = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD = 1'b1;
  localparam int CFG_DATA_W = 16;

  // Power code constants
  localparam logic [6:0] CODE_OFFSET   = 7'd110;
  localparam logic [6:0] CODE_DBM_HIGH = 7'd90;
  localparam logic [6:0] CODE_TOP      = 7'd127;
  localparam logic signed [7:0] DBM_LOW   = -8'sd110;
  localparam logic signed [7:0] DBM_HIGH  = -8'sd20;
  localparam logic signed [7:0] TGT_RESET = -8'sd40;
  localparam logic [15:0] PER_RESET = 16'd5;
  localparam logic [15:0] TICK_MAX  = 16'hFFFF;
  localparam logic [7:0]  RCPI_LIMIT = 8'd220;
  localparam logic [5:0]  MAX_RES = 6'd32;
  localparam int SUM_W = 24;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_REPORT = 2'd1,
    OP_TICK   = 2'd2,
    OP_INIT   = 2'd3
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [4:0] station;
    logic [7:0] rcpi;
    logic [4:0] uph_headroom;
    logic       uph_min_power;
  } in_item_t;

  typedef struct packed {
    logic [4:0] out_station;
    logic [6:0] target_power;
    logic       updated;
    logic       from_pass;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_MOD,
    S_TICK,
    S_SCAN,
    S_SWAIT,
    S_DIV,
    S_UPD,
    S_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_item;
    logic rd_item;
    logic wr_item;
    logic tick_upd;
    logic scan_clr;
    logic rd_scan;
    logic scan_adv;
    logic div_start;
    logic upd_write;
    logic fin;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic sta_ok;
    logic pass_go;
    logic active_cur;
    logic cnt_zero;
    logic div_done;
    logic idx_last;
    logic mod_stall;
    logic upd_stall;
    logic fin_stall;
  } stat_t;

endpackage

FILE: sv/upt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module upt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/upt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upt_ctrl
// Sequencer: decodes each request, walks stations in a maintenance pass.
// ----------------------------------------------------------------------------
module upt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  upt_pkg::stat_t st,
  output upt_pkg::cmd_t  cmd
);
  import upt_pkg::*;

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        if (st.op == OP_TICK) state_nxt = S_TICK;
        else if (!st.sta_ok)  state_nxt = S_IDLE;
        else                  state_nxt = S_MOD;
      end
      S_MOD:  if (!st.mod_stall) state_nxt = S_IDLE;
      S_TICK: state_nxt = st.pass_go ? S_SCAN : S_IDLE;
      S_SCAN: begin
        if (st.active_cur)    state_nxt = S_SWAIT;
        else if (st.idx_last) state_nxt = S_FIN;
      end
      S_SWAIT: begin
        if (!st.cnt_zero)     state_nxt = S_DIV;
        else if (st.idx_last) state_nxt = S_FIN;
        else                  state_nxt = S_SCAN;
      end
      S_DIV: if (st.div_done) state_nxt = S_UPD;
      S_UPD: begin
        if (!st.upd_stall) state_nxt = st.idx_last ? S_FIN : S_SCAN;
      end
      S_FIN: if (!st.fin_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.latch_item = in_valid;
      S_DEC:  cmd.rd_item = (st.op != OP_TICK) && st.sta_ok;
      S_MOD:  cmd.wr_item = !st.mod_stall;
      S_TICK: begin
        cmd.tick_upd = 1'b1;
        cmd.scan_clr = st.pass_go;
      end
      S_SCAN: begin
        cmd.rd_scan  = st.active_cur;
        cmd.scan_adv = !st.active_cur && !st.idx_last;
      end
      S_SWAIT: begin
        cmd.div_start = !st.cnt_zero;
        cmd.scan_adv  = st.cnt_zero && !st.idx_last;
      end
      S_DIV: ;
      S_UPD: begin
        cmd.upd_write = !st.upd_stall;
        cmd.scan_adv  = !st.upd_stall && !st.idx_last;
      end
      S_FIN: cmd.fin = !st.fin_stall;
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

FILE: sv/upt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upt_dp
// Datapath: station store, tick counter, averaging divider, target update
// and result buffering.
// ----------------------------------------------------------------------------
module upt_dp #(
  parameter int STATIONS   = upt_pkg::STATIONS_DEF,
  parameter int COUNT_BITS = upt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  upt_pkg::in_item_t               in_data,
  input  logic                            cfg_we,
  input  logic [upt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [upt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output upt_pkg::out_item_t              out_data,
  input  upt_pkg::cmd_t                   cmd,
  output upt_pkg::stat_t                  st
);
  import upt_pkg::*;

  localparam int IDX_W = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int ENT_W = 7 + 5 + 1 + SUM_W + COUNT_BITS;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STATIONS - 1);

  // Configuration and control registers
  logic signed [7:0]   cfg_tgt_r;
  logic [15:0]         cfg_per_r;
  logic [15:0]         tick_r;
  in_item_t            item_r;
  logic [IDX_W-1:0]    idx_r;
  logic [5:0]          nres_r;
  logic                visited_r;
  logic                held_valid_r;
  out_item_t           held_r;
  logic                out_valid_r;
  out_item_t           out_r;
  logic [STATIONS-1:0] active_r;
  logic [STATIONS-1:0] ent_vld_r;
  logic                rvld_r;

  // Divider registers
  logic [7:0]            dq_r;
  logic [SUM_W-1:0]      drem_r;
  logic [COUNT_BITS-1:0] dden_r;
  logic [2:0]            dstep_r;
  logic                  dbusy_r;

  // Station store
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata, ent;

  logic [6:0]       sta_ext;
  logic [IDX_W-1:0] item_idx;
  logic             sta_ok;

  assign sta_ext  = {2'b00, item_r.station};
  assign item_idx = sta_ext[IDX_W-1:0];
  assign sta_ok   = (32'(item_r.station) < 32'(STATIONS));

  assign ram_re    = cmd.rd_item || cmd.rd_scan;
  assign ram_raddr = cmd.rd_item ? item_idx : idx_r;
  assign ram_we    = cmd.wr_item || cmd.upd_write;
  assign ram_waddr = cmd.wr_item ? item_idx : idx_r;

  upt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STATIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Unwritten entries read as zero
  assign ent = rvld_r ? ram_rdata : '0;

  logic [6:0]            e_tgt;
  logic [4:0]            e_hr;
  logic                  e_mp;
  logic [SUM_W-1:0]      e_sum;
  logic [COUNT_BITS-1:0] e_cnt;

  assign e_tgt = ent[ENT_W-1 -: 7];
  assign e_hr  = ent[ENT_W-8 -: 5];
  assign e_mp  = ent[ENT_W-13];
  assign e_sum = ent[COUNT_BITS +: SUM_W];
  assign e_cnt = ent[COUNT_BITS-1:0];

  // Sample accumulate check
  logic [SUM_W:0] sum_add;
  logic           smp_ok;
  assign sum_add = {1'b0, e_sum} + (SUM_W + 1)'(item_r.rcpi);
  assign smp_ok  = (item_r.rcpi < RCPI_LIMIT) && (e_cnt != {COUNT_BITS{1'b1}}) &&
                   !sum_add[SUM_W];

  // Initial code from the configured dBm
  logic [8:0] icode9;
  logic [6:0] icode;
  assign icode9 = {cfg_tgt_r[7], cfg_tgt_r} + {2'b00, CODE_OFFSET};
  assign icode  = icode9[6:0];

  // Target update from the average
  logic [6:0]        rc, cur, nc, new_tgt;
  logic signed [9:0] cur_s, rc_s, diff_s, hr_s, next_s;
  logic              skip, apply;

  always_comb begin
    rc     = dq_r[7:1];
    cur    = (e_tgt > CODE_DBM_HIGH) ? CODE_DBM_HIGH : e_tgt;
    cur_s  = $signed({3'b000, cur});
    rc_s   = $signed({3'b000, rc});
    hr_s   = $signed({5'b00000, e_hr});
    diff_s = rc_s - cur_s;
    skip   = e_mp && (e_hr == 5'd0);
    apply  = 1'b0;
    next_s = cur_s;
    if (diff_s > 10'sd0 && !e_mp) begin
      next_s = cur_s - diff_s;
      apply  = 1'b1;
    end else if (diff_s < 10'sd0 && e_hr != 5'd0) begin
      next_s = (hr_s < -diff_s) ? (cur_s + hr_s) : (cur_s - diff_s);
      apply  = 1'b1;
    end
    if (next_s > $signed({3'b000, CODE_DBM_HIGH})) nc = CODE_TOP;
    else if (next_s < 10'sd0)                       nc = 7'd0;
    else                                            nc = next_s[6:0];
    new_tgt = (apply && !skip) ? nc : e_tgt;
  end

  // Write data for the store
  always_comb begin
    ram_wdata = ent;
    if (cmd.upd_write) begin
      ram_wdata = {new_tgt, e_hr, e_mp, {SUM_W{1'b0}}, {COUNT_BITS{1'b0}}};
    end else begin
      unique case (item_r.operation)
        OP_SAMPLE: if (smp_ok) begin
          ram_wdata = {e_tgt, e_hr, e_mp, sum_add[SUM_W-1:0],
                       e_cnt + COUNT_BITS'(1)};
        end
        OP_REPORT: ram_wdata = {e_tgt, item_r.uph_headroom, item_r.uph_min_power,
                                e_sum, e_cnt};
        OP_INIT:   ram_wdata = {icode, e_hr, e_mp, e_sum, e_cnt};
        OP_TICK:   ram_wdata = ent;
        default:   ram_wdata = ent;
      endcase
    end
  end

  // Tick counter
  logic [15:0] tick_inc;
  assign tick_inc = (tick_r == TICK_MAX) ? tick_r : tick_r + 16'd1;

  // Output side
  logic out_free, report_ok, out_push;
  out_item_t upd_res;
  assign out_free  = !out_valid_r || out_ready;
  assign report_ok = (nres_r < MAX_RES);
  assign out_push  = (cmd.wr_item && item_r.operation == OP_INIT) ||
                     (cmd.upd_write && report_ok && held_valid_r) ||
                     (cmd.fin && held_valid_r);

  always_comb begin
    logic [6:0] idx_ext;
    idx_ext = 7'(idx_r);
    upd_res.out_station  = idx_ext[4:0];
    upd_res.target_power = new_tgt;
    upd_res.updated      = (new_tgt != e_tgt);
    upd_res.from_pass    = 1'b1;
    upd_res.last         = 1'b0;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_tgt_r <= TGT_RESET;
      cfg_per_r <= PER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_TARGET: begin
          if ($signed(cfg_wdata[7:0]) >= DBM_LOW && $signed(cfg_wdata[7:0]) <= DBM_HIGH) begin
            cfg_tgt_r <= $signed(cfg_wdata[7:0]);
          end
        end
        CFG_IDX_PERIOD: cfg_per_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Latch request payload
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_r <= in_data;
    end
  end

  // Control state: store flags, tick, scan, results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      ent_vld_r    <= '0;
      rvld_r       <= 1'b0;
      tick_r       <= '0;
      idx_r        <= '0;
      nres_r       <= '0;
      visited_r    <= 1'b0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      dbusy_r      <= 1'b0;
    end else begin
      if (ram_re) begin
        rvld_r <= ent_vld_r[ram_raddr];
      end
      if (ram_we) begin
        ent_vld_r[ram_waddr] <= 1'b1;
      end
      if (cmd.wr_item && item_r.operation == OP_INIT) begin
        active_r[item_idx] <= 1'b1;
      end
      if (cmd.tick_upd) begin
        tick_r <= tick_inc;
      end else if (cmd.fin && visited_r) begin
        tick_r <= '0;
      end
      if (cmd.scan_clr) begin
        idx_r        <= '0;
        nres_r       <= '0;
        visited_r    <= 1'b0;
        held_valid_r <= 1'b0;
      end
      if (cmd.rd_scan) begin
        visited_r <= 1'b1;
      end
      if (cmd.scan_adv) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      // Divider sequencing
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && dstep_r == 3'd0) begin
        dbusy_r <= 1'b0;
      end
      // Push a new result, else drop the delivered one
      if (out_push) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.upd_write && report_ok) begin
        held_valid_r <= 1'b1;
        nres_r       <= nres_r + 6'd1;
      end
      if (cmd.fin) begin
        held_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.wr_item && item_r.operation == OP_INIT) begin
      out_r.out_station  <= item_r.station;
      out_r.target_power <= icode;
      out_r.updated      <= 1'b0;
      out_r.from_pass    <= 1'b0;
      out_r.last         <= 1'b1;
    end else if (cmd.upd_write && report_ok && held_valid_r) begin
      out_r <= held_r;
    end else if (cmd.fin && held_valid_r) begin
      out_r <= {held_r[$bits(out_item_t)-1:1], 1'b1};
    end
    if (cmd.upd_write && report_ok) begin
      held_r <= upd_res;
    end
  end

  // Average by restoring division; quotient stays below 256
  logic [31:0] rem32, sh32;
  assign rem32 = 32'(drem_r);
  assign sh32  = 32'(dden_r) << dstep_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      drem_r  <= e_sum;
      dden_r  <= e_cnt;
      dstep_r <= 3'd7;
      dq_r    <= '0;
    end else if (dbusy_r) begin
      if (rem32 >= sh32) begin
        drem_r         <= SUM_W'(rem32 - sh32);
        dq_r[dstep_r]  <= 1'b1;
      end
      dstep_r <= dstep_r - 3'd1;
    end
  end

  // Status to the sequencer
  always_comb begin
    st.op         = item_r.operation;
    st.sta_ok     = sta_ok;
    st.pass_go    = (tick_inc >= cfg_per_r);
    st.active_cur = active_r[idx_r];
    st.cnt_zero   = (e_cnt == '0);
    st.div_done   = !dbusy_r;
    st.idx_last   = (idx_r == IDX_LAST);
    st.mod_stall  = (item_r.operation == OP_INIT) && !out_free;
    st.upd_stall  = report_ok && held_valid_r && !out_free;
    st.fin_stall  = held_valid_r && !out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_nres_max: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= MAX_RES)
    else $error("result count above limit");

  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_re && ram_we))
    else $error("store read and write in one cycle");

  a_fin_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> !held_valid_r)
    else $error("held result not flushed at pass end");

  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> dbusy_r && dstep_r == 3'd7)
    else $error("divider did not start");

endmodule

FILE: sv/uplink_power_target_control_top.sv
`timescale 1ns / 1ps
// Sample and report requests update the station store, out-of-range ones are dropped;
//   an init result is loaded into the output register.
// A tick advances the tick counter and, once the period is reached, starts a pass over
//   all stations; each station with samples is averaged by the 8-step divider.
// One request at a time; reset (rst_n, synchronous) clears all station state.
// ----------------------------------------------------------------------------
// uplink_power_target_control_top
// Per-station uplink target receive power controller.
// ----------------------------------------------------------------------------
module uplink_power_target_control_top #(
  parameter int STATIONS   = upt_pkg::STATIONS_DEF,
  parameter int COUNT_BITS = upt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  upt_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output upt_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [upt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [upt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import upt_pkg::*;

  cmd_t  cmd;
  stat_t st;

  upt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  upt_dp #(
    .STATIONS   (STATIONS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample, report, tick and init requests into the uplink target-power
// controller, predicts every per-station target result in a local model and
// checks the results in order, under random idling and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import upt_pkg::*;

  localparam int NSTA = 32;
  localparam int CNT_MAX = 65535;
  localparam int SUM_LIM = 24'hFFFFFF;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  uplink_power_target_control_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Predictor state
  int init_dbm;
  int period;
  bit sta_active [NSTA];
  int tgt_code [NSTA];
  int hr_store [NSTA];
  bit minp_store [NSTA];
  int sum_acc [NSTA];
  int cnt_acc [NSTA];
  int ticks;

  out_item_t target_queue[$];
  int mismatches = 0;
  int results_seen = 0;
  int reqs_sent = 0;
  longint cycles = 0;
  bit idle_enable = 1'b1;
  bit hold_out = 1'b0;
  int hold_cycles = 0;

  function automatic int dbm_to_code(int dbm);
    if (dbm > -20) return 127;
    if (dbm < -110) return 0;
    return dbm + 110;
  endfunction

  function automatic int code_to_dbm(int code);
    if (code > 90) return -20;
    return code - 110;
  endfunction

  function automatic void reset_model();
    init_dbm = -40;
    period = 5;
    ticks = 0;
    for (int s = 0; s < NSTA; s++) begin
      sta_active[s] = 0; tgt_code[s] = 0; hr_store[s] = 0;
      minp_store[s] = 0; sum_acc[s] = 0; cnt_acc[s] = 0;
    end
  endfunction

  // Apply one station visit, return 1 when the code moved
  function automatic bit visit_station(int s);
    int old, avg, rdbm, cdbm, diff, nxt;
    bit apply, changed;
    old = tgt_code[s];
    apply = 0;
    changed = 0;
    if (!(minp_store[s] && hr_store[s] == 0)) begin
      avg = sum_acc[s] / cnt_acc[s];
      rdbm = (avg >> 1) - 110;
      cdbm = code_to_dbm(old);
      diff = rdbm - cdbm;
      nxt = cdbm;
      if (diff > 0 && !minp_store[s]) begin
        nxt = cdbm - diff; apply = 1;
      end else if (diff < 0 && hr_store[s] != 0) begin
        if (hr_store[s] < -diff) nxt = cdbm + hr_store[s];
        else nxt = cdbm - diff;
        apply = 1;
      end
      if (apply) begin
        changed = (dbm_to_code(nxt) != old);
        tgt_code[s] = dbm_to_code(nxt);
      end
    end
    sum_acc[s] = 0;
    cnt_acc[s] = 0;
    return changed;
  endfunction

  // Work out the results of one accepted request
  function automatic void predict_targets(in_item_t it);
    out_item_t r;
    int n, s;
    bit visited, upd;
    n = 0;
    s = int'(it.station);
    case (it.operation)
      OP_TICK: begin
        if (ticks < 16'hFFFF) ticks++;
        if (ticks >= period) begin
          visited = 0;
          for (int k = 0; k < NSTA; k++) begin
            if (sta_active[k]) begin
              visited = 1;
              if (cnt_acc[k] != 0) begin
                upd = visit_station(k);
                r.out_station = 5'(k);
                r.target_power = 7'(tgt_code[k]);
                r.updated = upd;
                r.from_pass = 1'b1;
                r.last = 1'b0;
                target_queue.push_back(r);
                n++;
              end
            end
          end
          if (visited) ticks = 0;
          if (n > 0) target_queue[$].last = 1'b1;
        end
      end
      OP_SAMPLE: begin
        if (it.rcpi < 220 && cnt_acc[s] < CNT_MAX && sum_acc[s] + it.rcpi <= SUM_LIM) begin
          sum_acc[s] += int'(it.rcpi);
          cnt_acc[s]++;
        end
      end
      OP_REPORT: begin
        hr_store[s] = int'(it.uph_headroom);
        minp_store[s] = it.uph_min_power;
      end
      default: begin
        sta_active[s] = 1;
        tgt_code[s] = dbm_to_code(init_dbm);
        r.out_station = 5'(s);
        r.target_power = 7'(tgt_code[s]);
        r.updated = 1'b0;
        r.from_pass = 1'b0;
        r.last = 1'b1;
        target_queue.push_back(r);
      end
    endcase
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_out) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      hold_cycles <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (target_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %p", out_data);
      end else begin
        exp_r = target_queue.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", exp_r, out_data);
        end
      end
    end
  end

  // Send one request and predict it on acceptance
  task automatic send_req(in_item_t it);
    if (idle_enable && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) @(negedge clk);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_targets(it);
    reqs_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
    // The block is still busy with this request here
    @(negedge clk);
  endtask

  task automatic send_op(op_t op, int sta, int rcpi, int hr, bit mp);
    in_item_t it;
    it.operation = op;
    it.station = 5'(sta);
    it.rcpi = 8'(rcpi);
    it.uph_headroom = 5'(hr);
    it.uph_min_power = mp;
    send_req(it);
  endtask

  task automatic wait_drain();
    while (target_queue.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int v;
    // Write only while no request is in flight
    while (!in_ready) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_TARGET) begin
      v = int'($signed(val[7:0]));
      if (v >= -110 && v <= -20) init_dbm = v;
    end else begin
      period = int'(val);
    end
    @(negedge clk);
  endtask

  task automatic random_req();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55)
      send_op(OP_SAMPLE, $urandom_range(0, 31),
              ($urandom_range(0, 9) == 0) ? $urandom_range(220, 255) : $urandom_range(0, 219),
              $urandom_range(0, 31), 1'($urandom_range(0, 1)));
    else if (sel < 70)
      send_op(OP_REPORT, $urandom_range(0, 31), $urandom_range(0, 255),
              ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 31),
              ($urandom_range(0, 3) == 0));
    else if (sel < 90)
      send_op(OP_TICK, $urandom, $urandom, $urandom, 1'($urandom));
    else
      send_op(OP_INIT, $urandom_range(0, 31), $urandom, $urandom, 1'($urandom));
  endtask

  // Directed: init extremes, reports, samples at edges, passes
  task automatic test_directed();
    write_reg(CFG_IDX_PERIOD, 16'd1);
    send_op(OP_TICK, 0, 0, 0, 0);
    send_op(OP_INIT, 0, 255, 31, 1);
    send_op(OP_INIT, 31, 0, 0, 0);
    send_op(OP_TICK, 0, 0, 0, 0);
    send_op(OP_SAMPLE, 0, 219, 0, 0);
    send_op(OP_SAMPLE, 0, 220, 0, 0);
    send_op(OP_SAMPLE, 0, 255, 0, 0);
    send_op(OP_SAMPLE, 31, 0, 0, 0);
    send_op(OP_SAMPLE, 5, 100, 0, 0);
    send_op(OP_REPORT, 31, 0, 31, 0);
    send_op(OP_TICK, 0, 0, 0, 0);
    send_op(OP_REPORT, 0, 0, 0, 1);
    send_op(OP_SAMPLE, 0, 10, 0, 0);
    send_op(OP_REPORT, 31, 0, 0, 1);
    send_op(OP_SAMPLE, 31, 200, 0, 0);
    send_op(OP_TICK, 31, 255, 31, 1);
    wait_drain();
    write_reg(CFG_IDX_TARGET, 16'h0092);
    write_reg(CFG_IDX_TARGET, 16'h0000);
    send_op(OP_INIT, 2, 0, 0, 0);
    write_reg(CFG_IDX_TARGET, 16'hFFEC);
    send_op(OP_INIT, 3, 0, 0, 0);
    write_reg(CFG_IDX_PERIOD, 16'd0);
    send_op(OP_SAMPLE, 3, 0, 0, 0);
    send_op(OP_TICK, 0, 0, 0, 0);
    wait_drain();
  endtask

  // Every station active with samples, so the pass gives 32 results while stalled
  task automatic test_full_pass();
    write_reg(CFG_IDX_PERIOD, 16'd3);
    for (int s = 0; s < NSTA; s++) begin
      send_op(OP_INIT, s, 0, 0, 0);
      send_op(OP_SAMPLE, s, $urandom_range(0, 219), 0, 0);
    end
    hold_out = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_out = 1'b0;
      end
      repeat (4) send_op(OP_TICK, 0, 0, 0, 0);
    join
    wait_drain();
  endtask

  task automatic test_random(int count, int per, logic [7:0] tgt);
    write_reg(CFG_IDX_PERIOD, 16'(per));
    write_reg(CFG_IDX_TARGET, {8'h00, tgt});
    for (int i = 0; i < count; i++) random_req();
    wait_drain();
  endtask

  initial begin
    reset_model();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_full_pass();
    test_random(130, 4, 8'hB0);
    test_random(100, 65535, 8'h92);
    write_reg(CFG_IDX_TARGET, 16'hFFD8);
    test_random(60, 2, 8'hEC);
    idle_enable = 1'b0;
    test_random(70, 1, 8'hC4);
    $display("Sent %0d requests and checked %0d target results over several settings",
             reqs_sent, results_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
